/* design/lea_pkg.sv */
// ----------------------------------------------------------------------------
// LEA-128 package
// Shared word types, register indexes and the rotate and delta helpers.
// ----------------------------------------------------------------------------
package lea_pkg;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 2'd1;

    // input word: one 16-byte block plus the operation flag
    typedef struct packed {
        logic        func;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } in_word_t;

    typedef struct packed {
        logic [63:0] result_high;
        logic [63:0] result_low;
    } out_word_t;

    // four 32-bit words, word 0 in the lowest bits
    typedef struct packed {
        logic [31:0] w3;
        logic [31:0] w2;
        logic [31:0] w1;
        logic [31:0] w0;
    } quad_t;

    localparam logic [31:0] DELTA_0 = 32'hc3efe9db;
    localparam logic [31:0] DELTA_1 = 32'h44626b02;
    localparam logic [31:0] DELTA_2 = 32'h79e27c8a;
    localparam logic [31:0] DELTA_3 = 32'h78df30ec;

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] delta_word(input logic [1:0] sel);
        logic [31:0] d;
        unique case (sel)
            2'd0:    d = DELTA_0;
            2'd1:    d = DELTA_1;
            2'd2:    d = DELTA_2;
            default: d = DELTA_3;
        endcase
        return d;
    endfunction

    // final rotate of key schedule word i
    function automatic logic [4:0] ks_rot(input logic [1:0] i);
        logic [4:0] n;
        unique case (i)
            2'd0:    n = 5'd1;
            2'd1:    n = 5'd3;
            2'd2:    n = 5'd6;
            default: n = 5'd11;
        endcase
        return n;
    endfunction

endpackage

/* design/lea_key_sched.sv */
// ----------------------------------------------------------------------------
// LEA-128 key schedule
// Expands the key into one round key per cycle and writes it to the store.
// ----------------------------------------------------------------------------
module lea_key_sched
    import lea_pkg::*;
#(
    parameter int ROUNDS = 24,
    parameter int AW     = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  quad_t         key,
    output logic          busy,
    output logic          wr_en,
    output logic [AW-1:0] wr_addr,
    output quad_t         wr_data
);

    logic          busy_reg;
    logic [AW-1:0] r_reg;
    quad_t         t_reg;
    quad_t         t_next;
    logic [4:0]    r5;
    logic [31:0]   d;

    assign r5 = 5'(r_reg);
    assign d  = delta_word(r5[1:0]);

    // four independent word lanes
    always_comb
    begin
        t_next.w0 = rol32(t_reg.w0 + rol32(d, r5),         ks_rot(2'd0));
        t_next.w1 = rol32(t_reg.w1 + rol32(d, r5 + 5'd1), ks_rot(2'd1));
        t_next.w2 = rol32(t_reg.w2 + rol32(d, r5 + 5'd2), ks_rot(2'd2));
        t_next.w3 = rol32(t_reg.w3 + rol32(d, r5 + 5'd3), ks_rot(2'd3));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            r_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            r_reg    <= '0;
        end
        else if (busy_reg)
        begin
            if (r_reg == AW'(ROUNDS - 1))
                busy_reg <= 1'b0;
            else
                r_reg <= r_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            t_reg <= key;
        else if (busy_reg)
            t_reg <= t_next;
    end

    assign busy    = busy_reg;
    assign wr_en   = busy_reg && !start;
    assign wr_addr = r_reg;
    assign wr_data = t_next;

endmodule

/* design/lea_round_dp.sv */
// ----------------------------------------------------------------------------
// LEA-128 round datapath
// Runs one ARX round per cycle on a stored round key, forward or backward.
// ----------------------------------------------------------------------------
module lea_round_dp
    import lea_pkg::*;
#(
    parameter int ROUNDS = 24,
    parameter int AW     = 5
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  in_word_t      in_word,
    output logic          out_valid,
    input  logic          out_stall,
    output out_word_t     out_word,
    input  logic          sched_busy,
    output logic          rd_en,
    output logic [AW-1:0] rd_addr,
    input  quad_t         rd_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    localparam logic [AW-1:0] LAST_ADDR = AW'(ROUNDS - 1);

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic          dec_reg;
    logic [AW-1:0] addr_reg;
    logic [AW-1:0] addr_next;
    quad_t         x_reg;
    quad_t         enc_x;
    quad_t         dec_x;
    logic          out_valid_reg;
    out_word_t     out_word_reg;
    logic          accept;
    logic          last;
    logic          out_load;
    logic [31:0]   p1;
    logic [31:0]   p2;

    assign in_stall = (state_reg != ST_IDLE) || sched_busy;
    assign accept   = in_valid && !in_stall;
    assign last     = dec_reg ? (addr_reg == '0) : (addr_reg == LAST_ADDR);
    assign addr_next = dec_reg ? (addr_reg - 1'b1) : (addr_reg + 1'b1);
    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    // forward round
    always_comb
    begin
        enc_x.w0 = rol32((x_reg.w0 ^ rd_data.w0) + (x_reg.w1 ^ rd_data.w1), 5'd9);
        enc_x.w1 = ror32((x_reg.w1 ^ rd_data.w2) + (x_reg.w2 ^ rd_data.w1), 5'd5);
        enc_x.w2 = ror32((x_reg.w2 ^ rd_data.w3) + (x_reg.w3 ^ rd_data.w1), 5'd3);
        enc_x.w3 = x_reg.w0;
    end

    // backward round
    always_comb
    begin
        p1 = (ror32(x_reg.w0, 5'd9) - (x_reg.w3 ^ rd_data.w0)) ^ rd_data.w1;
        p2 = (rol32(x_reg.w1, 5'd5) - (p1 ^ rd_data.w2)) ^ rd_data.w1;
        dec_x.w0 = x_reg.w3;
        dec_x.w1 = p1;
        dec_x.w2 = p2;
        dec_x.w3 = (rol32(x_reg.w2, 5'd3) - (p2 ^ rd_data.w3)) ^ rd_data.w1;
    end

    always_comb
    begin
        state_next = state_reg;
        rd_en      = 1'b0;
        rd_addr    = addr_next;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rd_en      = 1'b1;
                    rd_addr    = in_word.func ? LAST_ADDR : '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last)
                    state_next = ST_FIN;
                else
                    rd_en = 1'b1;
            end
            ST_FIN:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            addr_reg <= rd_addr;
        if (accept)
        begin
            dec_reg  <= in_word.func;
            x_reg.w0 <= in_word.block_low[31:0];
            x_reg.w1 <= in_word.block_low[63:32];
            x_reg.w2 <= in_word.block_high[31:0];
            x_reg.w3 <= in_word.block_high[63:32];
        end
        else if (state_reg == ST_RUN)
            x_reg <= dec_reg ? dec_x : enc_x;
        if (out_load)
        begin
            out_word_reg.result_low  <= {x_reg.w1, x_reg.w0};
            out_word_reg.result_high <= {x_reg.w3, x_reg.w2};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

/* design/lea128_block_cipher_unit.sv */
// ----------------------------------------------------------------------------
// LEA-128 block cipher unit
// Key registers, round key store and the round datapath around it.
// ----------------------------------------------------------------------------
// Usage:
//   Write the key through the config channel: index CFG_KEY_LOW takes key
//   bytes 0..7, index CFG_KEY_HIGH bytes 8..15. Every write to either index
//   expands the key again; other indexes are dropped. cfg_ready is always
//   high. Write the key only while the unit is idle.
//   Expansion fills the round key store one round key per cycle, so the
//   input channel stalls after each key write until the store is full.
//   Reset clears the key to zero and runs the same expansion, so in_stall
//   stays high after reset until that expansion is done.
//   Each input word carries one 16-byte block and func (0 encrypt,
//   1 decrypt). The datapath runs one ARX round per cycle, reading one
//   round key from the store each cycle, forward for encrypt and backward
//   for decrypt.
//   The unit takes no new block until the last one has left the datapath,
//   as there is a single round unit and only one read port on the store.
//   The result sits in an output register; while out_stall is high it is
//   held and the next block already runs. A finished block then waits in
//   the datapath until the output register frees up.
// ----------------------------------------------------------------------------
module lea128_block_cipher_unit
    import lea_pkg::*;
#(
    parameter int ROUNDS = 24
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    localparam int AW = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    logic [63:0]   key_low_reg;
    logic [63:0]   key_high_reg;
    logic          start_reg;
    logic          cfg_wr;
    logic          key_wr;
    quad_t         key;

    logic          sched_busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    quad_t         wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    quad_t         rd_data_reg;

    // round key store: one entry per round
    quad_t         rk_mem [ROUNDS];

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign key_wr    = cfg_wr && ((cfg_index == CFG_KEY_LOW) || (cfg_index == CFG_KEY_HIGH));

    // hold the key; start expansion the cycle after a key write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            start_reg    <= 1'b1;
        end
        else
        begin
            if (cfg_wr && (cfg_index == CFG_KEY_LOW))
                key_low_reg <= cfg_data;
            if (cfg_wr && (cfg_index == CFG_KEY_HIGH))
                key_high_reg <= cfg_data;
            start_reg <= key_wr;
        end
    end

    assign key.w0 = key_low_reg[31:0];
    assign key.w1 = key_low_reg[63:32];
    assign key.w2 = key_high_reg[31:0];
    assign key.w3 = key_high_reg[63:32];

    lea_key_sched #(
        .ROUNDS (ROUNDS),
        .AW     (AW)
    ) u_sched (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start_reg),
        .key     (key),
        .busy    (sched_busy),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    // writes and reads do not overlap while the key is written only when idle:
    // the datapath takes no block while the schedule runs or is about to start
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rk_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= rk_mem[rd_addr];
    end

    lea_round_dp #(
        .ROUNDS (ROUNDS),
        .AW     (AW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .sched_busy (sched_busy || start_reg),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data_reg)
    );

endmodule

/* design/lea_checker.sv */
// ----------------------------------------------------------------------------
// LEA-128 port checker
// Watches the ports of the cipher unit over time.
// ----------------------------------------------------------------------------
module lea_checker
    import lea_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic                 out_valid,
    input logic                 out_stall,
    input out_word_t            out_word,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index
);

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_word))
        else $error("stalled result changed");

    // one block at a time: an accepted block blocks the input
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a block is in flight");

    // a key write starts expansion, which blocks the input
    a_stall_on_key: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && ((cfg_index == CFG_KEY_LOW) || (cfg_index == CFG_KEY_HIGH))
        |=> ##1 in_stall)
        else $error("input open during key expansion");

endmodule

bind lea128_block_cipher_unit lea_checker u_lea_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index)
);
